// ----- design/qaa_pkg.sv -----
// Shared types and constants for the quaternion angle and axis block.
package qaa_pkg;

	// Input beat: current orientation quaternion
	typedef struct packed {
		logic signed [15:0] q_w;
		logic signed [15:0] q_x;
		logic signed [15:0] q_y;
		logic signed [15:0] q_z;
	} in_t;

	// Output beat: angle from reference and normalized rotation axis (z, x, y)
	typedef struct packed {
		logic        [14:0] angle;
		logic signed [15:0] axis_a;
		logic signed [15:0] axis_b;
		logic signed [15:0] axis_c;
		logic               axis_valid;
	} out_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_W = 2'd0,
		REG_X = 2'd1,
		REG_Y = 2'd2,
		REG_Z = 2'd3
	} reg_idx_t;

	localparam logic signed [15:0] REF_W_RST = 16'sd11235;
	localparam logic signed [15:0] REF_X_RST = 16'sd598;
	localparam logic signed [15:0] REF_Y_RST = -16'sd11906;
	localparam logic signed [15:0] REF_Z_RST = 16'sd0;

	// Square root: radicands below 2^61, roots of 31 bits
	localparam int SQ_W = 61;
	localparam int RT_W = 31;

	// Cross magnitudes are normalized so the largest has its top bit here
	localparam int NORM_TOP = 28;

	// CORDIC vectoring, angles in 1/16384 degree
	localparam int CORDIC_STEPS = 16;
	localparam logic [19:0] ATAN_TAB [CORDIC_STEPS] = '{
		20'd737280, 20'd435242, 20'd229970, 20'd116736,
		20'd58595,  20'd29326,  20'd14667,  20'd7334,
		20'd3667,   20'd1833,   20'd917,    20'd458,
		20'd229,    20'd115,    20'd57,     20'd29
	};
	localparam logic [21:0] DEG90_U  = 22'd1474560;
	localparam logic [21:0] DEG180_U = 22'd2949120;

	// Conversion from 1/16384 degree to 1/128 degree with rounding
	localparam logic [22:0] ANGLE_RND = 23'd64;
	localparam int          ANGLE_SH  = 7;

	localparam logic [15:0] AXIS_MAX = 16'd32767;

endpackage

// ----- design/qaa_sqrt_stage.sv -----
// One registered step of a digit-by-digit integer square root.
module qaa_sqrt_stage #(
	parameter int RAD_W  = 61,
	parameter int ROOT_W = 31,
	parameter int BIT    = 30
) (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rem_i,
	input  logic [ROOT_W-1:0] root_i,
	output logic [RAD_W-1:0]  rem_o,
	output logic [ROOT_W-1:0] root_o
);

	localparam int CW = ((RAD_W > ROOT_W + BIT + 1) ? RAD_W : ROOT_W + BIT + 1) + 1;

	logic [CW-1:0]     trial;
	logic              fits;
	logic [RAD_W-1:0]  rem_s1;
	logic [ROOT_W-1:0] root_s1;

	// Test whether this root bit can be set: (root + 2^b)^2 <= radicand
	assign trial = (CW'(root_i) << (BIT + 1)) + (CW'(1) << (2 * BIT));
	assign fits  = CW'(rem_i) >= trial;

	// Advance remainder and partial root
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= fits ? RAD_W'(CW'(rem_i) - trial) : rem_i;
			root_s1 <= fits ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
		end
	end

	assign rem_o  = rem_s1;
	assign root_o = root_s1;

endmodule

// ----- design/quaternion_angle_and_axis.sv -----
// Top level: rotation angle and axis of a quaternion against a reference.
//
//  channel | signals                        | direction | beat
//  --------+--------------------------------+-----------+-------------------------------
//  config  | cfg_we, cfg_idx, cfg_wdata     | in        | cfg_we high, no wait
//  input   | in_valid, in_ready, in_data    | in        | in_valid & in_ready
//  output  | out_valid, out_ready, out_data | out       | out_valid & out_ready
//
// One beat enters per cycle unless a waiting output beat stalls the pipeline. The stages
// are six setup stages, one stage per square root bit, then one stage per CORDIC step and
// per quotient bit of the axis divide, then the output register.
// Reset clears the reference to its default and empties the pipeline.
// When the output beat is not taken, every stage holds and in_ready drops.
module quaternion_angle_and_axis #(
	parameter int FRAC_BITS = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [15:0]   cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  qaa_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output qaa_pkg::out_t out_data
);

	import qaa_pkg::*;

	localparam int TWO_F = 2 * FRAC_BITS;
	localparam int QB    = FRAC_BITS + 1;
	localparam int NW    = 30 + FRAC_BITS;
	localparam int NT    = (QB > CORDIC_STEPS) ? QB : CORDIC_STEPS;
	localparam int NS    = 6 + RT_W + NT + 1;
	localparam int QX    = (QB > 16) ? QB : 16;
	localparam logic [63:0]     DOT_ONE = 64'(1) << TWO_F;
	localparam logic [SQ_W-1:0] SQ_ONE  = SQ_W'(1) << 60;

	logic signed [15:0] ref_w_q, ref_x_q, ref_y_q, ref_z_q;
	logic [NS-1:0]      vld_q;
	logic               en;

	// stage 1 products
	logic signed [31:0] pd_w_s1, pd_x_s1, pd_y_s1, pd_z_s1;
	logic signed [31:0] pc_xy_s1, pc_yx_s1, pc_yz_s1, pc_zy_s1, pc_zx_s1, pc_xz_s1;

	// stage 2
	logic signed [33:0] dot;
	logic [33:0]        dot_mag;
	logic [63:0]        dot_cl;
	logic [63:0]        m_full;
	logic signed [32:0] cr [3];
	logic [30:0]        m_s2;
	logic               neg_s2;
	logic [2:0]         sg_s2;
	logic [31:0]        cm_s2 [3];

	// stage 3
	logic [31:0]        mx;
	logic [4:0]         lead;
	logic [61:0]        mm_s3;
	logic [30:0]        m_s3;
	logic               neg_s3;
	logic [2:0]         sg_s3;
	logic [31:0]        cm_s3 [3];
	logic [4:0]         lead_s3;
	logic               zero_s3;

	// stage 4
	logic [4:0]         shl, shr;
	logic [SQ_W-1:0]    v_s4;
	logic [30:0]        m_s4;
	logic               neg_s4;
	logic [2:0]         sg_s4;
	logic [28:0]        cn_s4 [3];
	logic               zero_s4;

	// stage 5
	logic [SQ_W-1:0]    v_s5;
	logic [30:0]        m_s5;
	logic               neg_s5;
	logic [2:0]         sg_s5;
	logic [28:0]        cn_s5 [3];
	logic [57:0]        sqr_s5 [3];
	logic               zero_s5;

	// stage 6
	logic [SQ_W-1:0]    v_s6;
	logic [SQ_W-1:0]    sum_s6;
	logic [30:0]        m_s6;
	logic               neg_s6;
	logic [2:0]         sg_s6;
	logic [28:0]        cn_s6 [3];
	logic               zero_s6;

	// square root stages
	logic [SQ_W-1:0]    ar_rem  [RT_W+1];
	logic [RT_W-1:0]    ar_root [RT_W+1];
	logic [SQ_W-1:0]    nr_rem  [RT_W+1];
	logic [RT_W-1:0]    nr_root [RT_W+1];
	logic [30:0]        sq_m    [RT_W+1];
	logic               sq_neg  [RT_W+1];
	logic [2:0]         sq_sg   [RT_W+1];
	logic               sq_zero [RT_W+1];
	logic [28:0]        sq_cn   [RT_W+1][3];

	// CORDIC and divide stages
	logic signed [33:0] tl_x    [NT+1];
	logic signed [33:0] tl_y    [NT+1];
	logic signed [22:0] tl_z    [NT+1];
	logic [29:0]        tl_norm [NT+1];
	logic               tl_neg  [NT+1];
	logic [2:0]         tl_sg   [NT+1];
	logic               tl_zero [NT+1];
	logic [NW-1:0]      tl_rem  [NT+1][3];
	logic [QB-1:0]      tl_q    [NT+1][3];

	// final
	logic [21:0]        z_cl;
	logic [22:0]        t_deg;
	logic [15:0]        ax_mag [3];
	logic [15:0]        ax_val [3];
	out_t               res;
	out_t               out_q;

	// Global advance: hold every stage while the output beat waits
	assign en        = !vld_q[NS-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[NS-1];
	assign out_data  = out_q;

	// Reference registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_w_q <= REF_W_RST;
			ref_x_q <= REF_X_RST;
			ref_y_q <= REF_Y_RST;
			ref_z_q <= REF_Z_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_W:   ref_w_q <= $signed(cfg_wdata);
				REG_X:   ref_x_q <= $signed(cfg_wdata);
				REG_Y:   ref_y_q <= $signed(cfg_wdata);
				REG_Z:   ref_z_q <= $signed(cfg_wdata);
				default: ref_w_q <= ref_w_q;
			endcase
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	// Stage 1: dot and cross products
	always_ff @(posedge clk) begin
		if (en) begin
			pd_w_s1  <= ref_w_q * $signed(in_data.q_w);
			pd_x_s1  <= ref_x_q * $signed(in_data.q_x);
			pd_y_s1  <= ref_y_q * $signed(in_data.q_y);
			pd_z_s1  <= ref_z_q * $signed(in_data.q_z);
			pc_xy_s1 <= ref_x_q * $signed(in_data.q_y);
			pc_yx_s1 <= ref_y_q * $signed(in_data.q_x);
			pc_yz_s1 <= ref_y_q * $signed(in_data.q_z);
			pc_zy_s1 <= ref_z_q * $signed(in_data.q_y);
			pc_zx_s1 <= ref_z_q * $signed(in_data.q_x);
			pc_xz_s1 <= ref_x_q * $signed(in_data.q_z);
		end
	end

	// Stage 2: sum the dot, clamp to one, bring to Q30; form cross magnitudes
	assign dot = 34'(pd_w_s1) + 34'(pd_x_s1) + 34'(pd_y_s1) + 34'(pd_z_s1);
	assign dot_mag = dot[33] ? 34'(-dot) : 34'(dot);
	assign dot_cl = (64'(dot_mag) > DOT_ONE) ? DOT_ONE : 64'(dot_mag);

	if (TWO_F >= 30) begin : g_mdn
		assign m_full = dot_cl >> (TWO_F - 30);
	end else begin : g_mup
		assign m_full = dot_cl << (30 - TWO_F);
	end

	assign cr[0] = 33'(pc_xy_s1) - 33'(pc_yx_s1);
	assign cr[1] = 33'(pc_yz_s1) - 33'(pc_zy_s1);
	assign cr[2] = 33'(pc_zx_s1) - 33'(pc_xz_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2   <= m_full[30:0];
			neg_s2 <= dot[33];
			for (int i = 0; i < 3; i++) begin
				sg_s2[i] <= cr[i][32];
				cm_s2[i] <= cr[i][32] ? 32'(-cr[i]) : 32'(cr[i]);
			end
		end
	end

	// Stage 3: square m; find the largest cross magnitude and its top bit
	always_comb begin
		mx = cm_s2[0];
		if (cm_s2[1] > mx) mx = cm_s2[1];
		if (cm_s2[2] > mx) mx = cm_s2[2];
	end

	always_comb begin
		lead = '0;
		for (int i = 0; i < 32; i++) begin
			if (mx[i]) lead = 5'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mm_s3   <= m_s2 * m_s2;
			m_s3    <= m_s2;
			neg_s3  <= neg_s2;
			sg_s3   <= sg_s2;
			cm_s3   <= cm_s2;
			lead_s3 <= lead;
			zero_s3 <= (mx == '0);
		end
	end

	// Stage 4: radicand for the sine term; scale cross magnitudes to the top bit
	assign shl = 5'(NORM_TOP) - lead_s3;
	assign shr = lead_s3 - 5'(NORM_TOP);

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4    <= SQ_ONE - SQ_W'(mm_s3);
			m_s4    <= m_s3;
			neg_s4  <= neg_s3;
			sg_s4   <= sg_s3;
			zero_s4 <= zero_s3;
			for (int i = 0; i < 3; i++) begin
				cn_s4[i] <= (lead_s3 < 5'(NORM_TOP)) ? 29'(cm_s3[i] << shl)
				                                     : 29'(cm_s3[i] >> shr);
			end
		end
	end

	// Stage 5: squares of the scaled components
	always_ff @(posedge clk) begin
		if (en) begin
			v_s5    <= v_s4;
			m_s5    <= m_s4;
			neg_s5  <= neg_s4;
			sg_s5   <= sg_s4;
			cn_s5   <= cn_s4;
			zero_s5 <= zero_s4;
			for (int i = 0; i < 3; i++) begin
				sqr_s5[i] <= cn_s4[i] * cn_s4[i];
			end
		end
	end

	// Stage 6: sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6  <= SQ_W'(sqr_s5[0]) + SQ_W'(sqr_s5[1]) + SQ_W'(sqr_s5[2]);
			v_s6    <= v_s5;
			m_s6    <= m_s5;
			neg_s6  <= neg_s5;
			sg_s6   <= sg_s5;
			cn_s6   <= cn_s5;
			zero_s6 <= zero_s5;
		end
	end

	// Square root stages: sine term and cross norm side by side, one bit per stage
	assign ar_rem[0]  = v_s6;
	assign ar_root[0] = '0;
	assign nr_rem[0]  = sum_s6;
	assign nr_root[0] = '0;
	assign sq_m[0]    = m_s6;
	assign sq_neg[0]  = neg_s6;
	assign sq_sg[0]   = sg_s6;
	assign sq_zero[0] = zero_s6;
	assign sq_cn[0]   = cn_s6;

	for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
		qaa_sqrt_stage #(
			.RAD_W  (SQ_W),
			.ROOT_W (RT_W),
			.BIT    (RT_W - 1 - k)
		) u_ang (
			.clk    (clk),
			.en     (en),
			.rem_i  (ar_rem[k]),
			.root_i (ar_root[k]),
			.rem_o  (ar_rem[k+1]),
			.root_o (ar_root[k+1])
		);

		qaa_sqrt_stage #(
			.RAD_W  (SQ_W),
			.ROOT_W (RT_W),
			.BIT    (RT_W - 1 - k)
		) u_nrm (
			.clk    (clk),
			.en     (en),
			.rem_i  (nr_rem[k]),
			.root_i (nr_root[k]),
			.rem_o  (nr_rem[k+1]),
			.root_o (nr_root[k+1])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_m[k+1]    <= sq_m[k];
				sq_neg[k+1]  <= sq_neg[k];
				sq_sg[k+1]   <= sq_sg[k];
				sq_zero[k+1] <= sq_zero[k];
				sq_cn[k+1]   <= sq_cn[k];
			end
		end
	end

	// Tail entry: CORDIC vector (m, s), dividends with half-norm rounding
	assign tl_x[0]    = 34'(sq_m[RT_W]);
	assign tl_y[0]    = 34'(ar_root[RT_W]);
	assign tl_z[0]    = '0;
	assign tl_norm[0] = nr_root[RT_W][29:0];
	assign tl_neg[0]  = sq_neg[RT_W];
	assign tl_sg[0]   = sq_sg[RT_W];
	assign tl_zero[0] = sq_zero[RT_W];

	for (genvar j = 0; j < 3; j++) begin : g_div_in
		assign tl_rem[0][j] = (NW'(sq_cn[RT_W][j]) << FRAC_BITS)
		                      + NW'(nr_root[RT_W][29:1]);
		assign tl_q[0][j]   = '0;
	end

	// Tail stages: one CORDIC rotation and one quotient bit per stage; stages past either count pass it through
	for (genvar k = 0; k < NT; k++) begin : g_tail
		logic signed [33:0] x_n, y_n;
		logic signed [22:0] z_n;
		logic [NW-1:0]      rem_n [3];
		logic [QB-1:0]      q_n   [3];

		if (k < CORDIC_STEPS) begin : g_rot
			always_comb begin
				if (tl_y[k] > 34'sd0) begin
					x_n = tl_x[k] + (tl_y[k] >>> k);
					y_n = tl_y[k] - (tl_x[k] >>> k);
					z_n = tl_z[k] + $signed(23'(ATAN_TAB[k]));
				end else begin
					x_n = tl_x[k] - (tl_y[k] >>> k);
					y_n = tl_y[k] + (tl_x[k] >>> k);
					z_n = tl_z[k] - $signed(23'(ATAN_TAB[k]));
				end
			end
		end else begin : g_rot_hold
			assign x_n = tl_x[k];
			assign y_n = tl_y[k];
			assign z_n = tl_z[k];
		end

		for (genvar j = 0; j < 3; j++) begin : g_lane
			if (k < QB) begin : g_div
				localparam int QI = QB - 1 - k;
				logic [NW-1:0] dv;
				logic          take;
				assign dv       = NW'(tl_norm[k]) << QI;
				assign take     = tl_rem[k][j] >= dv;
				assign rem_n[j] = take ? (tl_rem[k][j] - dv) : tl_rem[k][j];
				assign q_n[j]   = take ? (tl_q[k][j] | (QB'(1) << QI)) : tl_q[k][j];
			end else begin : g_div_hold
				assign rem_n[j] = tl_rem[k][j];
				assign q_n[j]   = tl_q[k][j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tl_x[k+1]    <= x_n;
				tl_y[k+1]    <= y_n;
				tl_z[k+1]    <= z_n;
				tl_norm[k+1] <= tl_norm[k];
				tl_neg[k+1]  <= tl_neg[k];
				tl_sg[k+1]   <= tl_sg[k];
				tl_zero[k+1] <= tl_zero[k];
				tl_rem[k+1]  <= rem_n;
				tl_q[k+1]    <= q_n;
			end
		end
	end

	// Final: clamp angle to zero..quarter turn, mirror for negative dot, round
	always_comb begin
		if (tl_z[NT][22]) begin
			z_cl = '0;
		end else if (tl_z[NT][21:0] > DEG90_U) begin
			z_cl = DEG90_U;
		end else begin
			z_cl = tl_z[NT][21:0];
		end
		t_deg = tl_neg[NT] ? 23'(DEG180_U - z_cl) : 23'(z_cl);
	end

	// Saturate axis magnitudes and apply signs
	for (genvar j = 0; j < 3; j++) begin : g_axis
		logic [QX-1:0] qw;
		assign qw        = QX'(tl_q[NT][j]);
		assign ax_mag[j] = (qw > QX'(AXIS_MAX)) ? AXIS_MAX : 16'(qw);
		assign ax_val[j] = tl_zero[NT] ? 16'd0
		                 : (tl_sg[NT][j] ? 16'(-ax_mag[j]) : ax_mag[j]);
	end

	always_comb begin
		res.angle      = 15'((t_deg + ANGLE_RND) >> ANGLE_SH);
		res.axis_a     = $signed(ax_val[0]);
		res.axis_b     = $signed(ax_val[1]);
		res.axis_c     = $signed(ax_val[2]);
		res.axis_valid = !tl_zero[NT];
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res;
		end
	end

	// Ready drops only while a result waits at the output
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a waiting output beat");

	// A zero cross product gives a zero axis
	a_zero_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.axis_valid) |->
		(out_data.axis_a == 16'sd0 && out_data.axis_b == 16'sd0 &&
		 out_data.axis_c == 16'sd0))
		else $error("axis not cleared for zero cross product");

	// Angle never exceeds a half turn
	a_angle_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.angle <= 15'd23040))
		else $error("angle beyond half turn");

	// A beat in the stage before the output register reaches the output when the pipeline advances
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[NS-2]) |=> out_valid)
		else $error("pipeline beat lost before output");

endmodule

// ----- sim/quaternion_angle_and_axis_tb.sv -----
// Self-checking testbench for the quaternion angle and axis block.
`timescale 1ns / 1ps

module quaternion_angle_and_axis_tb;
	import qaa_pkg::*;

	localparam int FRAC = 14;
	localparam int PIPE_LAT = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_RANDOM = 430;

	// Scoreboard: predicts angle and axis, holds expected beats in order
	class angle_axis_board;
		logic signed [15:0] rw, rx, ry, rz;
		out_t pending[$];
		int errors;

		function new();
			rw = REF_W_RST;
			rx = REF_X_RST;
			ry = REF_Y_RST;
			rz = REF_Z_RST;
			errors = 0;
		endfunction

		function void write_ref(reg_idx_t idx, logic [15:0] v);
			case (idx)
				REG_W: rw = v;
				REG_X: rx = v;
				REG_Y: ry = v;
				REG_Z: rz = v;
				default: ;
			endcase
		endfunction

		static function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		static function longint floor_shift(longint v, int s);
			return v >>> s;
		endfunction

		// Compute expected beat for one input quaternion
		function out_t predict(in_t q);
			longint dot, x, y, z, t, dx, dy, sv;
			longint cr[3];
			longint unsigned u, m, s, mx, sum, norm, a;
			longint unsigned cm[3];
			bit neg;
			out_t r;
			dot = longint'(rw) * q.q_w + longint'(rx) * q.q_x
				+ longint'(ry) * q.q_y + longint'(rz) * q.q_z;
			neg = dot < 0;
			u = neg ? -dot : dot;
			if (u > (64'd1 << (2 * FRAC))) u = 64'd1 << (2 * FRAC);
			m = (2 * FRAC >= 30) ? u >> (2 * FRAC - 30) : u << (30 - 2 * FRAC);
			s = int_sqrt((64'd1 << 60) - m * m);
			x = m;
			y = s;
			z = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = floor_shift(y, i);
				dy = floor_shift(x, i);
				if (y > 0) begin
					x += dx; y -= dy; z += ATAN_TAB[i];
				end else begin
					x -= dx; y += dy; z -= ATAN_TAB[i];
				end
			end
			if (z < 0) z = 0;
			if (z > longint'(DEG90_U)) z = DEG90_U;
			t = neg ? longint'(DEG180_U) - z : z;
			r.angle = 15'((t + 64) >> 7);
			cr[0] = longint'(rx) * q.q_y - longint'(ry) * q.q_x;
			cr[1] = longint'(ry) * q.q_z - longint'(rz) * q.q_y;
			cr[2] = longint'(rz) * q.q_x - longint'(rx) * q.q_z;
			mx = 0;
			for (int i = 0; i < 3; i++) begin
				cm[i] = cr[i] < 0 ? -cr[i] : cr[i];
				if (cm[i] > mx) mx = cm[i];
			end
			r.axis_a = 0;
			r.axis_b = 0;
			r.axis_c = 0;
			r.axis_valid = 0;
			if (mx == 0) return r;
			while (mx < (64'd1 << 28)) begin
				mx = mx << 1;
				for (int i = 0; i < 3; i++) cm[i] = cm[i] << 1;
			end
			while (mx >= (64'd1 << 29)) begin
				mx = mx >> 1;
				for (int i = 0; i < 3; i++) cm[i] = cm[i] >> 1;
			end
			sum = cm[0] * cm[0] + cm[1] * cm[1] + cm[2] * cm[2];
			norm = int_sqrt(sum);
			for (int i = 0; i < 3; i++) begin
				a = ((cm[i] << FRAC) + (norm >> 1)) / norm;
				if (a > AXIS_MAX) a = AXIS_MAX;
				sv = cr[i] < 0 ? -longint'(a) : longint'(a);
				case (i)
					0: r.axis_a = 16'(sv);
					1: r.axis_b = 16'(sv);
					default: r.axis_c = 16'(sv);
				endcase
			end
			r.axis_valid = 1;
			return r;
		endfunction

		function void note_input(in_t q);
			pending.push_back(predict(q));
		endfunction

		function void check_result(out_t got);
			out_t e;
			if (pending.size() == 0) begin
				$error("unexpected output beat %p", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.angle !== e.angle) begin
				$error("angle: expected %0d, got %0d", e.angle, got.angle);
				errors++;
			end
			if (got.axis_a !== e.axis_a) begin
				$error("axis_a: expected %0d, got %0d", e.axis_a, got.axis_a);
				errors++;
			end
			if (got.axis_b !== e.axis_b) begin
				$error("axis_b: expected %0d, got %0d", e.axis_b, got.axis_b);
				errors++;
			end
			if (got.axis_c !== e.axis_c) begin
				$error("axis_c: expected %0d, got %0d", e.axis_c, got.axis_c);
				errors++;
			end
			if (got.axis_valid !== e.axis_valid) begin
				$error("axis_valid: expected %0d, got %0d", e.axis_valid, got.axis_valid);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [15:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	angle_axis_board board;
	int idle_cycles;
	bit stall_free;

	quaternion_angle_and_axis #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		board = new();
		stall_free = 0;
	end

	// Note accepted input beats and check accepted output beats
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) board.note_input(in_data);
		if (arst_n && out_valid && out_ready) board.check_result(out_data);
	end

	// Watchdog: count cycles with no beat moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("** quaternion_angle_and_axis: FAILED **");
				$finish;
			end
		end
	end

	// Receiver: random stall before each beat, sometimes none
	initial begin
		int w;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			w = stall_free ? 0 : $urandom_range(0, 4);
			if (w > 0) begin
				out_ready <= 0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Hold valid and payload until accepted; valid stays high for a following beat
	task automatic send_beat(input in_t q);
		int w;
		w = stall_free ? 0 : $urandom_range(0, 4);
		if (w > 0) begin
			in_valid <= 0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= q;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_ref(input reg_idx_t idx, input logic [15:0] v);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		board.write_ref(idx, v);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	task automatic set_ref(input int w, input int x, input int y, input int z);
		drain();
		write_ref(REG_W, 16'(w));
		write_ref(REG_X, 16'(x));
		write_ref(REG_Y, 16'(y));
		write_ref(REG_Z, 16'(z));
		cfg_we <= 0;
	endtask

	function automatic logic [15:0] rand_comp();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 16'($urandom);
		if (sel == 1) return 16'sd16384;
		if (sel == 2) return -16'sd16384;
		if (sel == 3) return 16'd0;
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic in_t rand_quat();
		in_t q;
		q.q_w = rand_comp();
		q.q_x = rand_comp();
		q.q_y = rand_comp();
		q.q_z = rand_comp();
		return q;
	endfunction

	function automatic in_t mk(input int w, input int x, input int y, input int z);
		in_t q;
		q.q_w = 16'(w);
		q.q_x = 16'(x);
		q.q_y = 16'(y);
		q.q_z = 16'(z);
		return q;
	endfunction

	initial begin
		in_t q;
		cfg_we = 0;
		cfg_idx = REG_W;
		cfg_wdata = 0;
		in_valid = 0;
		in_data = '0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset reference, equal and opposite quaternions, zero cross
		send_beat(mk(11235, 598, -11906, 0));
		send_beat(mk(-11235, -598, 11906, 0));
		send_beat(mk(16384, 0, 0, 0));
		send_beat(mk(0, 16384, 0, 0));
		send_beat(mk(0, 0, 0, 16384));
		send_beat(mk(0, 0, 0, 0));
		send_beat(mk(16384, 16384, -16384, 16384));
		send_beat(mk(-16384, -16384, 16384, -16384));
		send_beat(mk(32767, -32768, 32767, -32768));
		send_beat(mk(-32768, 32767, -32768, 32767));
		send_beat(mk(-1, -1, -1, -1));

		// Directed: extreme reference with dot clamped beyond one
		set_ref(16384, 16384, 16384, 16384);
		send_beat(mk(16384, 16384, 16384, 16384));
		send_beat(mk(-16384, -16384, -16384, -16384));
		send_beat(mk(16384, -16384, 16384, 0));
		send_beat(mk(0, 1, 0, 0));
		set_ref(-16384, -16384, -16384, -16384);
		send_beat(mk(16384, 0, 0, 0));
		send_beat(mk(1, 1, -1, 0));
		set_ref(32767, -32768, 32767, -32768);
		send_beat(mk(32767, 32767, 32767, 32767));
		send_beat(mk(-32768, -32768, 0, 1));
		set_ref(0, 0, 0, 0);
		send_beat(mk(16384, 16384, 16384, 16384));
		send_beat(mk(-32768, 32767, 1, -1));

		// Random: new reference every phase, stall-free stretches mixed in
		set_ref(int'(REF_W_RST), int'(REF_X_RST), int'(REF_Y_RST), int'(REF_Z_RST));
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 60 == 59) begin
				set_ref(int'(rand_comp()), int'(rand_comp()),
					int'(rand_comp()), int'(rand_comp()));
				stall_free = ($urandom_range(0, 2) == 0);
			end
			q = rand_quat();
			if ($urandom_range(0, 7) == 0) q.q_x = q.q_y;
			send_beat(q);
		end

		stall_free = 0;
		drain();
		if (board.errors == 0) begin
			$display("** quaternion_angle_and_axis: PASSED **");
		end else begin
			$display("** quaternion_angle_and_axis: FAILED **");
		end
		$finish;
	end
endmodule
